FILE: src/c2s_pkg.sv
// Types, constants and the arctangent table shared by the Cartesian to spherical block.
// Depends on nothing.
`timescale 1ns / 1ps
package c2s_pkg;

    localparam int SQRT_STEPS   = 32;   // one result bit per square-root cell
    localparam int CORDIC_STEPS = 20;   // one micro-rotation per CORDIC cell
    localparam int SQ_REM_W     = 35;   // partial remainder of the root
    localparam int VEC_W        = 52;   // CORDIC vector, Q16.16 coordinates scaled by 2^16
    localparam int ACC_W        = 24;   // angle accumulator, signed Q2.20
    localparam int ANG_W        = 18;   // output angle, Q2.16

    localparam logic [ANG_W-1:0]        ANG_PI_Q16  = 18'd205887;
    localparam logic signed [ACC_W-1:0] HALF_PI_Q20 = 24'sd1647099;

    typedef enum logic [1:0] {
        ANG_RUN,
        ANG_ZERO,
        ANG_PI
    } t_ang_fix;

    typedef struct packed {
        logic signed [VEC_W-1:0] vx;
        logic signed [VEC_W-1:0] vy;
        logic signed [ACC_W-1:0] acc;
    } t_cvec;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [31:0]        w;
        logic               zero;
    } t_side1;

    typedef struct packed {
        logic [31:0] rho;
        logic [31:0] r;
        logic [31:0] w;
        logic        zero;
        t_ang_fix    az_fix;
        t_ang_fix    po_fix;
    } t_side2;

    // atan(2^-i) in Q2.20
    function automatic logic signed [ACC_W-1:0] c2s_atan(input logic [4:0] idx);
        logic signed [ACC_W-1:0] v;
        unique case (idx)
            5'd0:    v = 24'sd823550;
            5'd1:    v = 24'sd486170;
            5'd2:    v = 24'sd256879;
            5'd3:    v = 24'sd130396;
            5'd4:    v = 24'sd65451;
            5'd5:    v = 24'sd32757;
            5'd6:    v = 24'sd16383;
            5'd7:    v = 24'sd8192;
            5'd8:    v = 24'sd4096;
            5'd9:    v = 24'sd2048;
            5'd10:   v = 24'sd1024;
            5'd11:   v = 24'sd512;
            5'd12:   v = 24'sd256;
            5'd13:   v = 24'sd128;
            5'd14:   v = 24'sd64;
            5'd15:   v = 24'sd32;
            5'd16:   v = 24'sd16;
            5'd17:   v = 24'sd8;
            5'd18:   v = 24'sd4;
            5'd19:   v = 24'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Start vector of atan2(b, a), b >= 0; a negative a is turned by -pi/2 first.
    function automatic t_cvec c2s_prerot(input logic signed [31:0] a, input logic [31:0] b);
        t_cvec                   v;
        logic signed [VEC_W-1:0] as;
        logic signed [VEC_W-1:0] bs;
        as = {{4{a[31]}}, a, 16'b0};
        bs = {4'b0, b, 16'b0};
        if (a[31]) begin
            v.vx  = bs;
            v.vy  = -as;
            v.acc = HALF_PI_Q20;
        end else begin
            v.vx  = as;
            v.vy  = bs;
            v.acc = '0;
        end
        return v;
    endfunction

endpackage

FILE: src/cartesian_to_spherical.sv
// Top level of the Cartesian to spherical converter: squares, root and CORDIC chains.
// Depends on c2s_pkg, c2s_sqrt_cell, c2s_cordic_cell, c2s_angle_end.
`timescale 1ns / 1ps
// Usage
//   Input channel : i_in_valid / o_in_ready with signed Q16.16 x, y, z, w.
//   Output channel: o_out_valid / i_out_ready with radius, planar radius (Q16.16),
//                   azimuth and polar angle (Q2.16 radians), w echoed and a zero flag.
//   Throughput    : one item per cycle, sustained, while the receiver takes items.
//   Pipeline      : from acceptance to o_out_valid an item passes 3 stages of
//                   magnitude/square/sum, 32 square-root cells (one root bit each),
//                   1 pre-rotation stage, 20 CORDIC cells and 1 rounding stage
//                   that doubles as the output register.
//   Stall         : the whole row of cells moves together. When the output holds an
//                   item and i_out_ready is low, every stage freezes and o_in_ready
//                   drops in the same cycle; an empty output slot keeps input open.
//   Reset         : i_rst_n (synchronous, active low) clears the stage valid bits
//                   only; data registers are left as they are.
//   Angles        : azimuth = atan2(|y|, x), polar = atan2(rho, z); both run as
//                   parallel CORDIC chains after the root, azimuth ignoring y's sign.
module cartesian_to_spherical
    import c2s_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_x_coord,
    input  logic signed [31:0] i_y_coord,
    input  logic signed [31:0] i_z_coord,
    input  logic signed [31:0] i_w_coord,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [31:0]        o_radius,
    output logic [31:0]        o_planar_radius,
    output logic [ANG_W-1:0]   o_azimuth,
    output logic [ANG_W-1:0]   o_polar_angle,
    output logic signed [31:0] o_w_out,
    output logic               o_is_zero
);

    localparam int NSTAGE = SQRT_STEPS + CORDIC_STEPS + 5;
    localparam int S1_N   = SQRT_STEPS + 3;
    localparam int S2_N   = CORDIC_STEPS + 1;

    // stage valid bits; everything advances together
    logic              r_vld [NSTAGE];
    logic              r_adv;

    // front end: magnitudes, squares, sums
    logic [31:0]       r_mx, r_my, r_mz;
    logic [63:0]       r_sq_x, r_sq_y, r_sq_z;
    logic [63:0]       r_sum_xy, r_sum_xyz;
    t_side1            r_s1 [S1_N];

    // square-root chains
    logic [SQ_REM_W-1:0] pr_rem [SQRT_STEPS];
    logic [31:0]         pr_root [SQRT_STEPS];
    logic [63:0]         pr_rad [SQRT_STEPS];
    logic [SQ_REM_W-1:0] sr_rem [SQRT_STEPS];
    logic [31:0]         sr_root [SQRT_STEPS];
    logic [63:0]         sr_rad [SQRT_STEPS];

    // CORDIC chains
    t_cvec             r_az0, r_po0;
    t_cvec             az_vec [CORDIC_STEPS];
    t_cvec             po_vec [CORDIC_STEPS];
    t_side2            r_s2 [S2_N];
    t_side2            n_s2;
    t_side1            s1_end;
    logic [31:0]       my_end;

    // output register
    logic [31:0]       r_o_r, r_o_rho, r_o_w;
    logic              r_o_zero;

    assign r_adv      = !r_vld[NSTAGE-1] || i_out_ready;
    assign o_in_ready = r_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NSTAGE; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (r_adv) begin
            r_vld[0] <= i_in_valid;
            for (int i = 1; i < NSTAGE; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    // magnitude, square, sum
    always_ff @(posedge i_clk) begin
        if (r_adv) begin
            r_mx      <= i_x_coord[31] ? (~i_x_coord + 32'd1) : i_x_coord;
            r_my      <= i_y_coord[31] ? (~i_y_coord + 32'd1) : i_y_coord;
            r_mz      <= i_z_coord[31] ? (~i_z_coord + 32'd1) : i_z_coord;
            r_sq_x    <= r_mx * r_mx;
            r_sq_y    <= r_my * r_my;
            r_sq_z    <= r_mz * r_mz;
            r_sum_xy  <= r_sq_x + r_sq_y;
            r_sum_xyz <= r_sq_x + r_sq_y + r_sq_z;
            r_s1[0]   <= '{x: i_x_coord, y: i_y_coord, z: i_z_coord,
                           w: i_w_coord, zero: (i_x_coord == 0) && (i_y_coord == 0)
                                               && (i_z_coord == 0) && (i_w_coord == 0)};
            for (int i = 1; i < S1_N; i++) begin
                r_s1[i] <= r_s1[i-1];
            end
        end
    end

    genvar k;
    generate
        for (k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
            if (k == 0) begin : g_first
                c2s_sqrt_cell u_pr (
                    .i_clk(i_clk), .i_en(r_adv),
                    .i_rem('0), .i_root('0), .i_rad(r_sum_xy),
                    .o_rem(pr_rem[k]), .o_root(pr_root[k]), .o_rad(pr_rad[k])
                );
                c2s_sqrt_cell u_sr (
                    .i_clk(i_clk), .i_en(r_adv),
                    .i_rem('0), .i_root('0), .i_rad(r_sum_xyz),
                    .o_rem(sr_rem[k]), .o_root(sr_root[k]), .o_rad(sr_rad[k])
                );
            end else begin : g_next
                c2s_sqrt_cell u_pr (
                    .i_clk(i_clk), .i_en(r_adv),
                    .i_rem(pr_rem[k-1]), .i_root(pr_root[k-1]), .i_rad(pr_rad[k-1]),
                    .o_rem(pr_rem[k]), .o_root(pr_root[k]), .o_rad(pr_rad[k])
                );
                c2s_sqrt_cell u_sr (
                    .i_clk(i_clk), .i_en(r_adv),
                    .i_rem(sr_rem[k-1]), .i_root(sr_root[k-1]), .i_rad(sr_rad[k-1]),
                    .o_rem(sr_rem[k]), .o_root(sr_root[k]), .o_rad(sr_rad[k])
                );
            end
        end
    endgenerate

    // pre-rotation and special-case decode
    always_comb begin
        s1_end = r_s1[S1_N-1];
        my_end = s1_end.y[31] ? (~s1_end.y + 32'd1) : s1_end.y;
        n_s2.rho  = pr_root[SQRT_STEPS-1];
        n_s2.r    = sr_root[SQRT_STEPS-1];
        n_s2.w    = s1_end.w;
        n_s2.zero = s1_end.zero;
        // y = 0 gives 0, or pi for a negative x; x = y = 0 thus gives 0
        if (my_end == 0) begin
            n_s2.az_fix = (s1_end.x[31]) ? ANG_PI : ANG_ZERO;
        end else begin
            n_s2.az_fix = ANG_RUN;
        end
        // rho = 0: on the z axis (or at the origin, where z = 0 too)
        if (pr_root[SQRT_STEPS-1] == 0) begin
            n_s2.po_fix = (s1_end.z[31]) ? ANG_PI : ANG_ZERO;
        end else begin
            n_s2.po_fix = ANG_RUN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_adv) begin
            r_az0   <= c2s_prerot(s1_end.x, my_end);
            r_po0   <= c2s_prerot(s1_end.z, pr_root[SQRT_STEPS-1]);
            r_s2[0] <= n_s2;
            for (int i = 1; i < S2_N; i++) begin
                r_s2[i] <= r_s2[i-1];
            end
        end
    end

    genvar j;
    generate
        for (j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
            c2s_cordic_cell #(.STEP(j)) u_az (
                .i_clk(i_clk), .i_en(r_adv),
                .i_vec((j == 0) ? r_az0 : az_vec[(j == 0) ? 0 : j-1]),
                .o_vec(az_vec[j])
            );
            c2s_cordic_cell #(.STEP(j)) u_po (
                .i_clk(i_clk), .i_en(r_adv),
                .i_vec((j == 0) ? r_po0 : po_vec[(j == 0) ? 0 : j-1]),
                .o_vec(po_vec[j])
            );
        end
    endgenerate

    c2s_angle_end u_az_end (
        .i_clk(i_clk), .i_en(r_adv),
        .i_acc(az_vec[CORDIC_STEPS-1].acc), .i_fix(r_s2[S2_N-1].az_fix),
        .o_angle(o_azimuth)
    );

    c2s_angle_end u_po_end (
        .i_clk(i_clk), .i_en(r_adv),
        .i_acc(po_vec[CORDIC_STEPS-1].acc), .i_fix(r_s2[S2_N-1].po_fix),
        .o_angle(o_polar_angle)
    );

    always_ff @(posedge i_clk) begin
        if (r_adv) begin
            r_o_r    <= r_s2[S2_N-1].r;
            r_o_rho  <= r_s2[S2_N-1].rho;
            r_o_w    <= r_s2[S2_N-1].w;
            r_o_zero <= r_s2[S2_N-1].zero;
        end
    end

    assign o_out_valid     = r_vld[NSTAGE-1];
    assign o_radius        = r_o_r;
    assign o_planar_radius = r_o_rho;
    assign o_w_out         = r_o_w;
    assign o_is_zero       = r_o_zero;

    // a frozen row keeps its valid bits (the first and the last are checked)
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_adv |=> $stable(o_out_valid) && $stable(r_vld[0]))
        else $error("stage valid bits moved during a stall");

    a_ready_only_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input blocked without a stalled output");

    a_zero_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_zero) |-> (o_radius == 0 && o_planar_radius == 0
                                        && o_azimuth == 0 && o_polar_angle == 0))
        else $error("zero point with non-zero result");

    a_radius_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_planar_radius <= o_radius))
        else $error("planar radius exceeds radius");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_azimuth <= ANG_PI_Q16 && o_polar_angle <= ANG_PI_Q16))
        else $error("angle above pi");

endmodule

FILE: src/c2s_sqrt_cell.sv
// One digit of the restoring integer square root: two radicand bits in, one root bit out.
// Depends on c2s_pkg.
`timescale 1ns / 1ps
module c2s_sqrt_cell
    import c2s_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [SQ_REM_W-1:0] i_rem,
    input  logic [31:0]         i_root,
    input  logic [63:0]         i_rad,
    output logic [SQ_REM_W-1:0] o_rem,
    output logic [31:0]         o_root,
    output logic [63:0]         o_rad
);

    logic [SQ_REM_W-1:0] r_rem, n_rem;
    logic [31:0]         r_root, n_root;
    logic [63:0]         r_rad, n_rad;
    logic [SQ_REM_W-1:0] rem_s;
    logic [SQ_REM_W-1:0] trial;
    logic                ge;

    always_comb begin
        rem_s  = {i_rem[SQ_REM_W-3:0], i_rad[63:62]};
        trial  = {1'b0, i_root, 2'b01};
        ge     = (rem_s >= trial);
        n_rem  = ge ? (rem_s - trial) : rem_s;
        n_root = {i_root[30:0], ge};
        n_rad  = {i_rad[61:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rad  <= n_rad;
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_rad  = r_rad;

endmodule

FILE: src/c2s_cordic_cell.sv
// One CORDIC vectoring micro-rotation with a fixed shift STEP.
// Depends on c2s_pkg.
`timescale 1ns / 1ps
module c2s_cordic_cell
    import c2s_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_cvec i_vec,
    output t_cvec o_vec
);

    t_cvec                   r_vec, n_vec;
    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;

    always_comb begin
        dx = i_vec.vy >>> STEP;   // arithmetic shift floors
        dy = i_vec.vx >>> STEP;
        if (i_vec.vy > 0) begin
            n_vec.vx  = i_vec.vx + dx;
            n_vec.vy  = i_vec.vy - dy;
            n_vec.acc = i_vec.acc + c2s_atan(5'(STEP));
        end else begin
            n_vec.vx  = i_vec.vx - dx;
            n_vec.vy  = i_vec.vy + dy;
            n_vec.acc = i_vec.acc - c2s_atan(5'(STEP));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= n_vec;
        end
    end

    assign o_vec = r_vec;

endmodule

FILE: src/c2s_angle_end.sv
// Final angle stage: special cases, round Q2.20 half up to Q2.16, clamp to [0, pi].
// Depends on c2s_pkg.
`timescale 1ns / 1ps
module c2s_angle_end
    import c2s_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [ACC_W-1:0] i_acc,
    input  t_ang_fix                i_fix,
    output logic [ANG_W-1:0]        o_angle
);

    logic [ANG_W-1:0] r_angle, n_angle;
    logic [ACC_W-1:0] rnd;
    logic [ACC_W-5:0] q;

    always_comb begin
        rnd = i_acc + 24'sd8;
        q   = rnd[ACC_W-1:4];
        unique case (i_fix)
            ANG_ZERO: n_angle = '0;
            ANG_PI:   n_angle = ANG_PI_Q16;
            ANG_RUN: begin
                if (i_acc < 0) begin
                    n_angle = '0;
                end else if (q > {2'b0, ANG_PI_Q16}) begin
                    n_angle = ANG_PI_Q16;
                end else begin
                    n_angle = q[ANG_W-1:0];
                end
            end
            default:  n_angle = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= n_angle;
        end
    end

    assign o_angle = r_angle;

endmodule
